// File: hw/rtl/eoe_pkg.sv
// shared constants, types and lookup functions for the exif orientation extractor
// no dependencies; imported by every module of the block
package eoe_pkg;

  localparam int unsigned STORE_BYTES = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
  localparam int unsigned LEN_W       = $clog2(STORE_BYTES + 1);
  localparam int unsigned PTR_W       = LEN_W + 1;

  localparam logic [1:0] KIND_JPEG = 2'd0;
  localparam logic [1:0] KIND_WEBP = 2'd1;
  localparam logic [1:0] KIND_PNG  = 2'd2;

  localparam logic [7:0] MK_PAD   = 8'hFF;
  localparam logic [7:0] MK_SOI   = 8'hD8;
  localparam logic [7:0] MK_EOI   = 8'hD9;
  localparam logic [7:0] MK_TEM   = 8'h01;
  localparam logic [7:0] MK_RST0  = 8'hD0;
  localparam logic [7:0] MK_RST7  = 8'hD7;
  localparam logic [7:0] MK_SOS   = 8'hDA;
  localparam logic [7:0] MK_APP1  = 8'hE1;

  localparam logic [15:0] TAG_ORIENT  = 16'h0112;
  localparam logic [15:0] TIFF_MAGIC  = 16'd42;
  localparam logic [15:0] TYPE_SHORT  = 16'd3;
  localparam logic [3:0]  ENTRY_BYTES = 4'd12;
  localparam logic [7:0]  ORDER_LE    = 8'h49;
  localparam logic [7:0]  ORDER_BE    = 8'h4D;

  localparam logic [2:0] PREFIX_LEN    = 3'd6;
  localparam logic [2:0] PREFIX_FAILED = 3'd7;

  localparam logic [3:0] ORIENT_DEFAULT = 4'd1;

  typedef enum logic [1:0] {
    SEC_HDR = 2'd0,
    SEC_CNT = 2'd1,
    SEC_ENT = 2'd2
  } sec_e;

  typedef struct packed {
    logic load;
    logic take;
    sec_e sec;
    logic ent_begin;
    logic ent_next;
    logic res_one;
    logic res_val;
  } walk_cmd_t;

  typedef struct packed {
    logic len_short;
    logic sec_end;
    logic hdr_bad;
    logic ent_fit;
    logic ent_hit;
  } walk_sts_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] kind, input logic [3:0] idx);
    logic [7:0] r;
    r = 8'h00;
    case (kind)
      KIND_JPEG: begin
        case (idx)
          4'd0:    r = 8'hFF;
          4'd1:    r = 8'hD8;
          default: r = 8'h00;
        endcase
      end
      KIND_WEBP: begin
        case (idx)
          4'd0:    r = 8'h52;
          4'd1:    r = 8'h49;
          4'd2:    r = 8'h46;
          4'd3:    r = 8'h46;
          4'd8:    r = 8'h57;
          4'd9:    r = 8'h45;
          4'd10:   r = 8'h42;
          4'd11:   r = 8'h50;
          default: r = 8'h00;
        endcase
      end
      KIND_PNG: begin
        case (idx)
          4'd0:    r = 8'h89;
          4'd1:    r = 8'h50;
          4'd2:    r = 8'h4E;
          4'd3:    r = 8'h47;
          4'd4:    r = 8'h0D;
          4'd5:    r = 8'h0A;
          4'd6:    r = 8'h1A;
          4'd7:    r = 8'h0A;
          default: r = 8'h00;
        endcase
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] sig_len(input logic [1:0] kind);
    logic [3:0] r;
    case (kind)
      KIND_JPEG: r = 4'd2;
      KIND_WEBP: r = 4'd12;
      default:   r = 4'd8;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // exif chunk name: upper case for webp, mixed case for png
  function automatic logic [7:0] chunk_name(input logic webp, input logic [1:0] p);
    logic [7:0] r;
    case (p)
      2'd0:    r = webp ? 8'h45 : 8'h65;
      2'd1:    r = 8'h58;
      2'd2:    r = 8'h49;
      default: r = webp ? 8'h46 : 8'h66;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] iend_byte(input logic [1:0] p);
    logic [7:0] r;
    case (p)
      2'd0:    r = 8'h49;
      2'd1:    r = 8'h45;
      2'd2:    r = 8'h4E;
      default: r = 8'h44;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/eoe_scan.sv
// byte-level container parser: signature, jpeg markers, riff/png chunks
// depends on eoe_pkg; drives store writes and starts the tiff walk
module eoe_scan import eoe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  logic [1:0]        kind_i,
  output logic              st_we_o,
  output logic [ADDR_W-1:0] st_addr_o,
  output logic [7:0]        st_data_o,
  output logic              walk_start_o,
  output logic              walk_base6_o,
  output logic [LEN_W-1:0]  walk_len_o,
  output logic              emit_one_o
);

  typedef enum logic [10:0] {
    PH_SIG   = 11'b00000000001,
    PH_JSEEK = 11'b00000000010,
    PH_JFF   = 11'b00000000100,
    PH_JLEN  = 11'b00000001000,
    PH_JSKIP = 11'b00000010000,
    PH_JPAY  = 11'b00000100000,
    PH_CHDR  = 11'b00001000000,
    PH_CPAY  = 11'b00010000000,
    PH_CSKIP = 11'b00100000000,
    PH_CTAIL = 11'b01000000000,
    PH_DONE  = 11'b10000000000
  } scan_ph_e;

  scan_ph_e          ph_q, ph_d;
  logic [3:0]        idx_q, idx_d;
  logic [7:0]        mk_q, mk_d;
  logic [31:0]       la_q, la_d;
  logic [31:0]       seg_q, seg_d;
  logic [2:0]        pfx_q, pfx_d;
  logic [LEN_W-1:0]  tlen_q, tlen_d;
  logic              sent_q, sent_d;

  logic              webp;
  logic [31:0]       seg_dec;
  logic              seg_one;
  logic              room;
  logic [LEN_W-1:0]  pay_tlen;
  logic [2:0]        pay_pfx;
  logic              pay_base6;
  logic [LEN_W-1:0]  pay_len;
  logic [15:0]       la16;
  logic [2:0]        k;
  logic [1:0]        p;
  logic              type_byte;
  logic [7:0]        mk_n;
  logic [31:0]       la_n;

  assign webp      = (kind_i == KIND_WEBP);
  assign seg_dec   = seg_q - 32'd1;
  assign seg_one   = (seg_q == 32'd1);
  assign room      = (tlen_q < LEN_W'(STORE_BYTES));
  assign pay_tlen  = room ? tlen_q + LEN_W'(1) : tlen_q;
  assign pay_pfx   = (pfx_q < PREFIX_LEN) ?
                     ((byte_i == prefix_byte(pfx_q)) ? pfx_q + 3'd1 : PREFIX_FAILED) : pfx_q;
  assign pay_base6 = (pay_pfx == PREFIX_LEN);
  assign pay_len   = pay_tlen - (pay_base6 ? LEN_W'(6) : LEN_W'(0));
  assign la16      = {la_q[7:0], byte_i};
  assign k         = idx_q[2:0];
  assign p         = k[1:0];
  assign type_byte = webp ? !k[2] : k[2];

  assign st_addr_o = tlen_q[ADDR_W-1:0];
  assign st_data_o = byte_i;

  always_comb begin
    ph_d   = ph_q;
    idx_d  = idx_q;
    mk_d   = mk_q;
    la_d   = la_q;
    seg_d  = seg_q;
    pfx_d  = pfx_q;
    tlen_d = tlen_q;
    sent_d = sent_q;
    st_we_o      = 1'b0;
    walk_start_o = 1'b0;
    walk_base6_o = 1'b0;
    walk_len_o   = pay_len;
    emit_one_o   = 1'b0;
    mk_n = mk_q;
    la_n = la_q;
    if (type_byte) begin
      if (byte_i != chunk_name(webp, p)) mk_n = mk_n & 8'd2;
      if (webp || byte_i != iend_byte(p)) mk_n = mk_n & 8'd1;
    end else if (webp) begin
      la_n = la_q | ({24'd0, byte_i} << {p, 3'b000});
    end else begin
      la_n = {la_q[23:0], byte_i};
    end

    if (acc_i) begin
      case (ph_q)
        PH_SIG: begin
          if (kind_i > KIND_PNG) begin
            ph_d = PH_DONE;
          end else if (idx_q < 4'd12 && !(webp && idx_q >= 4'd4 && idx_q < 4'd8)
                       && byte_i != sig_byte(kind_i, idx_q)) begin
            ph_d = PH_DONE;
          end else begin
            idx_d = idx_q + 4'd1;
            if (idx_d >= sig_len(kind_i)) begin
              if (kind_i == KIND_JPEG) begin
                ph_d = PH_JSEEK;
              end else begin
                ph_d  = PH_CHDR;
                idx_d = 4'd0;
                la_d  = 32'd0;
                mk_d  = 8'd3;
              end
            end
          end
        end
        PH_JSEEK: begin
          if (byte_i == MK_PAD) ph_d = PH_JFF;
        end
        PH_JFF: begin
          if (byte_i == MK_PAD) begin
            ph_d = PH_JFF;
          end else if (byte_i == MK_SOI || byte_i == MK_EOI || byte_i == MK_TEM
                       || (byte_i >= MK_RST0 && byte_i <= MK_RST7)) begin
            ph_d = PH_JSEEK;
          end else if (byte_i == MK_SOS) begin
            ph_d = PH_DONE;
          end else begin
            mk_d  = byte_i;
            idx_d = 4'd0;
            la_d  = 32'd0;
            ph_d  = PH_JLEN;
          end
        end
        PH_JLEN: begin
          la_d  = {16'd0, la16};
          idx_d = idx_q + 4'd1;
          if (idx_q != 4'd0) begin
            if (la16 < 16'd2) begin
              ph_d = PH_DONE;
            end else begin
              seg_d = {16'd0, la16 - 16'd2};
              if (mk_q == MK_APP1) begin
                tlen_d = '0;
                pfx_d  = 3'd0;
                ph_d   = (la16 == 16'd2) ? PH_JSEEK : PH_JPAY;
              end else begin
                ph_d   = (la16 == 16'd2) ? PH_JSEEK : PH_JSKIP;
              end
            end
          end
        end
        PH_JSKIP: begin
          seg_d = seg_dec;
          if (seg_one) ph_d = PH_JSEEK;
        end
        PH_JPAY: begin
          st_we_o = room;
          tlen_d  = pay_tlen;
          pfx_d   = pay_pfx;
          seg_d   = seg_dec;
          if (seg_one) begin
            if (pay_base6) begin
              walk_start_o = 1'b1;
              walk_base6_o = 1'b1;
              sent_d       = 1'b1;
              ph_d         = PH_DONE;
            end else begin
              ph_d = PH_JSEEK;
            end
          end
        end
        PH_CHDR: begin
          mk_d  = mk_n;
          la_d  = la_n;
          idx_d = idx_q + 4'd1;
          if (k == 3'd7) begin
            if (mk_n[0]) begin
              seg_d  = la_n;
              tlen_d = '0;
              pfx_d  = 3'd0;
              ph_d   = PH_CPAY;
              if (la_n == 32'd0) begin
                // empty exif chunk walks zero bytes
                walk_start_o = 1'b1;
                walk_len_o   = '0;
                sent_d       = 1'b1;
                ph_d         = PH_DONE;
              end
            end else if (!webp && mk_n[1]) begin
              ph_d = PH_DONE;
            end else if (la_n != 32'd0) begin
              seg_d = la_n;
              ph_d  = PH_CSKIP;
            end else if (!webp) begin
              seg_d = 32'd4;
              ph_d  = PH_CTAIL;
            end else begin
              // zero-length webp chunk has no pad byte
              idx_d = 4'd0;
              la_d  = 32'd0;
              mk_d  = 8'd3;
            end
          end
        end
        PH_CPAY: begin
          st_we_o = room;
          tlen_d  = pay_tlen;
          pfx_d   = pay_pfx;
          seg_d   = seg_dec;
          if (seg_one) begin
            walk_start_o = 1'b1;
            walk_base6_o = pay_base6;
            sent_d       = 1'b1;
            ph_d         = PH_DONE;
          end
        end
        PH_CSKIP: begin
          seg_d = seg_dec;
          if (seg_one) begin
            if (!webp) begin
              seg_d = 32'd4;
              ph_d  = PH_CTAIL;
            end else if (la_q[0]) begin
              seg_d = 32'd1;
              ph_d  = PH_CTAIL;
            end else begin
              ph_d  = PH_CHDR;
              idx_d = 4'd0;
              la_d  = 32'd0;
              mk_d  = 8'd3;
            end
          end
        end
        PH_CTAIL: begin
          seg_d = seg_dec;
          if (seg_one) begin
            ph_d  = PH_CHDR;
            idx_d = 4'd0;
            la_d  = 32'd0;
            mk_d  = 8'd3;
          end
        end
        default: begin
          ph_d = ph_q;
        end
      endcase

      if (last_i) begin
        emit_one_o = !sent_d;
        ph_d   = PH_SIG;
        idx_d  = 4'd0;
        mk_d   = 8'd0;
        la_d   = 32'd0;
        seg_d  = 32'd0;
        pfx_d  = 3'd0;
        tlen_d = '0;
        sent_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_SIG;
      idx_q  <= 4'd0;
      mk_q   <= 8'd0;
      la_q   <= 32'd0;
      seg_q  <= 32'd0;
      pfx_q  <= 3'd0;
      tlen_q <= '0;
      sent_q <= 1'b0;
    end else begin
      ph_q   <= ph_d;
      idx_q  <= idx_d;
      mk_q   <= mk_d;
      la_q   <= la_d;
      seg_q  <= seg_d;
      pfx_q  <= pfx_d;
      tlen_q <= tlen_d;
      sent_q <= sent_d;
    end
  end

endmodule

// File: hw/rtl/eoe_dp.sv
// tiff walk datapath: payload store, byte assembly, address and entry counters
// depends on eoe_pkg; commanded by eoe_ctrl
module eoe_dp import eoe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  walk_cmd_t         cmd_i,
  input  logic              base6_i,
  input  logic [LEN_W-1:0]  len_i,
  input  logic              st_we_i,
  input  logic [ADDR_W-1:0] st_addr_i,
  input  logic [7:0]        st_data_i,
  output walk_sts_t         sts_o,
  output logic [3:0]        res_o
);

  logic [7:0]        mem [STORE_BYTES];
  logic [7:0]        rdata_q;

  logic [PTR_W-1:0]  base_q, end_q, addr_q, pos_q;
  logic [LEN_W-1:0]  len_q;
  logic [3:0]        j_q;
  logic              little_q;
  logic [31:0]       acc_q;
  logic [15:0]       widx_q, count_q;
  logic              tag_ok_q, type_ok_q, cnt_ok_q;
  logic [3:0]        res_q;

  logic [31:0]       acc_new;
  logic [15:0]       f16;
  logic [PTR_W-1:0]  base_n;
  logic              off_bad;
  logic [PTR_W:0]    pos_end;

  assign acc_new = little_q ? {rdata_q, acc_q[31:8]} : {acc_q[23:0], rdata_q};
  assign f16     = little_q ? acc_new[31:16] : acc_new[15:0];
  assign base_n  = base6_i ? PTR_W'(6) : PTR_W'(0);
  assign off_bad = ({1'b0, acc_new} + 33'd2) > 33'(len_q);
  assign pos_end = {1'b0, pos_q} + (PTR_W + 1)'(ENTRY_BYTES);

  always_comb begin
    sts_o.len_short = (len_q < LEN_W'(8));
    sts_o.ent_fit   = (widx_q < count_q) && (pos_end <= {1'b0, end_q});
    sts_o.ent_hit   = tag_ok_q && type_ok_q && cnt_ok_q;
    sts_o.sec_end   = 1'b0;
    sts_o.hdr_bad   = 1'b0;
    case (cmd_i.sec)
      SEC_HDR: begin
        sts_o.sec_end = (j_q == 4'd7);
        case (j_q)
          4'd1:    sts_o.hdr_bad = !(acc_q[7:0] == rdata_q
                                     && (rdata_q == ORDER_LE || rdata_q == ORDER_BE));
          4'd3:    sts_o.hdr_bad = (f16 != TIFF_MAGIC);
          4'd7:    sts_o.hdr_bad = off_bad;
          default: sts_o.hdr_bad = 1'b0;
        endcase
      end
      SEC_CNT: sts_o.sec_end = (j_q == 4'd1);
      SEC_ENT: sts_o.sec_end = (j_q == 4'd9);
      default: sts_o.sec_end = 1'b0;
    endcase
  end

  assign res_o = res_q;

  // payload store, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (st_we_i) mem[st_addr_i] <= st_data_i;
    rdata_q <= mem[addr_q[ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      end_q     <= '0;
      addr_q    <= '0;
      pos_q     <= '0;
      len_q     <= '0;
      j_q       <= 4'd0;
      little_q  <= 1'b0;
      acc_q     <= 32'd0;
      widx_q    <= 16'd0;
      count_q   <= 16'd0;
      tag_ok_q  <= 1'b0;
      type_ok_q <= 1'b0;
      cnt_ok_q  <= 1'b0;
      res_q     <= ORIENT_DEFAULT;
    end else begin
      if (cmd_i.load) begin
        base_q   <= base_n;
        len_q    <= len_i;
        end_q    <= base_n + PTR_W'(len_i);
        addr_q   <= base_n;
        j_q      <= 4'd0;
        little_q <= 1'b0;
        widx_q   <= 16'd0;
      end else if (cmd_i.take) begin
        acc_q  <= acc_new;
        j_q    <= j_q + 4'd1;
        addr_q <= addr_q + PTR_W'(1);
        case (cmd_i.sec)
          SEC_HDR: begin
            if (j_q == 4'd1) little_q <= (rdata_q == ORDER_LE);
            if (j_q == 4'd7) begin
              addr_q <= base_q + acc_new[PTR_W-1:0];
              j_q    <= 4'd0;
            end
          end
          SEC_CNT: begin
            if (j_q == 4'd1) begin
              count_q <= f16;
              pos_q   <= addr_q + PTR_W'(1);
              j_q     <= 4'd0;
            end
          end
          SEC_ENT: begin
            if (j_q == 4'd1) tag_ok_q  <= (f16 == TAG_ORIENT);
            if (j_q == 4'd3) type_ok_q <= (f16 == TYPE_SHORT);
            if (j_q == 4'd7) cnt_ok_q  <= (acc_new == 32'd1);
            if (j_q == 4'd9) j_q <= 4'd0;
          end
          default: j_q <= j_q + 4'd1;
        endcase
      end
      if (cmd_i.ent_begin) begin
        addr_q <= pos_q;
        j_q    <= 4'd0;
      end
      if (cmd_i.ent_next) begin
        pos_q  <= pos_q + PTR_W'(ENTRY_BYTES);
        widx_q <= widx_q + 16'd1;
      end
      if (cmd_i.res_one) res_q <= ORIENT_DEFAULT;
      if (cmd_i.res_val) begin
        res_q <= (f16 >= 16'd1 && f16 <= 16'd8) ? f16[3:0] : ORIENT_DEFAULT;
      end
    end
  end

endmodule

// File: hw/rtl/eoe_ctrl.sv
// tiff walk sequencer: steps header, entry count and ifd0 entries byte by byte
// depends on eoe_pkg; drives eoe_dp through walk_cmd_t
module eoe_ctrl import eoe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      walk_start_i,
  input  walk_sts_t sts_i,
  output walk_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_CHECK   = 10'b0000000010,
    S_HDR_RD  = 10'b0000000100,
    S_HDR_USE = 10'b0000001000,
    S_CNT_RD  = 10'b0000010000,
    S_CNT_USE = 10'b0000100000,
    S_ENT_CHK = 10'b0001000000,
    S_ENT_RD  = 10'b0010000000,
    S_ENT_USE = 10'b0100000000,
    S_OUT     = 10'b1000000000
  } walk_st_e;

  walk_st_e st_q, st_d;

  always_comb begin
    st_d  = st_q;
    cmd_o = '{load: 1'b0, take: 1'b0, sec: SEC_HDR, ent_begin: 1'b0,
              ent_next: 1'b0, res_one: 1'b0, res_val: 1'b0};
    case (st_q)
      S_IDLE: begin
        if (walk_start_i) begin
          cmd_o.load = 1'b1;
          st_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.len_short) begin
          cmd_o.res_one = 1'b1;
          st_d          = S_OUT;
        end else begin
          st_d = S_HDR_RD;
        end
      end
      S_HDR_RD: st_d = S_HDR_USE;
      S_HDR_USE: begin
        cmd_o.take = 1'b1;
        if (sts_i.hdr_bad) begin
          cmd_o.res_one = 1'b1;
          st_d          = S_OUT;
        end else if (sts_i.sec_end) begin
          st_d = S_CNT_RD;
        end else begin
          st_d = S_HDR_RD;
        end
      end
      S_CNT_RD: begin
        cmd_o.sec = SEC_CNT;
        st_d      = S_CNT_USE;
      end
      S_CNT_USE: begin
        cmd_o.sec  = SEC_CNT;
        cmd_o.take = 1'b1;
        st_d       = sts_i.sec_end ? S_ENT_CHK : S_CNT_RD;
      end
      S_ENT_CHK: begin
        cmd_o.sec = SEC_ENT;
        if (sts_i.ent_fit) begin
          cmd_o.ent_begin = 1'b1;
          st_d            = S_ENT_RD;
        end else begin
          cmd_o.res_one = 1'b1;
          st_d          = S_OUT;
        end
      end
      S_ENT_RD: begin
        cmd_o.sec = SEC_ENT;
        st_d      = S_ENT_USE;
      end
      S_ENT_USE: begin
        cmd_o.sec  = SEC_ENT;
        cmd_o.take = 1'b1;
        if (!sts_i.sec_end) begin
          st_d = S_ENT_RD;
        end else if (sts_i.ent_hit) begin
          cmd_o.res_val = 1'b1;
          st_d          = S_OUT;
        end else begin
          cmd_o.ent_next = 1'b1;
          st_d           = S_ENT_CHK;
        end
      end
      S_OUT:   st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  assign busy_o = (st_q != S_IDLE);
  assign done_o = (st_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: hw/rtl/exif_orientation_extractor.sv
// top level of the exif orientation extractor: config register, handshakes, output register
// depends on eoe_pkg, eoe_scan, eoe_ctrl and eoe_dp
//
// usage
//   set container_kind over the apb port (address 0: 0 jpeg, 1 webp, 2 png) while idle
//   stream the file in one byte per input beat, last_byte_i high on its final byte
//   exactly one orientation beat (1..8) comes out per file
// throughput
//   bytes are taken one per cycle while the container is parsed and in_stall_o is low
//   when the exif payload ends, the ifd0 walk runs on the payload store with one
//   registered read port, reading each byte and then using it, with in_stall_o high
//   meanwhile; then the result sits in the output register
//   a missing or bad tag gives 1: from the walk when it ran, else from the beat that carries last_byte
// reset
//   asynchronous, active low; kind returns to jpeg and the parser to the
//   signature check; store contents are kept but never read before being written
// stalls
//   a held result keeps orientation_o stable; input beats are refused only while
//   the walk runs or while a result waits and out_stall_i is high
module exif_orientation_extractor import eoe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input byte channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  orientation_o
);

  logic [1:0]        kind_q;
  logic              out_valid_q;
  logic [3:0]        orient_q;

  logic              in_acc;
  logic              st_we;
  logic [ADDR_W-1:0] st_addr;
  logic [7:0]        st_data;
  logic              walk_start;
  logic              walk_base6;
  logic [LEN_W-1:0]  walk_len;
  logic              emit_one;
  walk_cmd_t         walk_cmd;
  walk_sts_t         walk_sts;
  logic              walk_busy;
  logic              walk_done;
  logic [3:0]        walk_res;

  // config register, single word; paddr is not decoded
  assign pready = 1'b1;
  assign prdata = {30'd0, kind_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_JPEG;
    end else if (psel && penable && pwrite) begin
      kind_q <= pwdata[1:0];
    end
  end

  // a beat is refused while walking or while the held result cannot leave
  assign in_stall_o = walk_busy || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  eoe_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (in_acc),
    .byte_i       (data_byte_i),
    .last_i       (last_byte_i),
    .kind_i       (kind_q),
    .st_we_o      (st_we),
    .st_addr_o    (st_addr),
    .st_data_o    (st_data),
    .walk_start_o (walk_start),
    .walk_base6_o (walk_base6),
    .walk_len_o   (walk_len),
    .emit_one_o   (emit_one)
  );

  eoe_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .walk_start_i (walk_start),
    .sts_i        (walk_sts),
    .cmd_o        (walk_cmd),
    .busy_o       (walk_busy),
    .done_o       (walk_done)
  );

  eoe_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (walk_cmd),
    .base6_i   (walk_base6),
    .len_i     (walk_len),
    .st_we_i   (st_we),
    .st_addr_i (st_addr),
    .st_data_i (st_data),
    .sts_o     (walk_sts),
    .res_o     (walk_res)
  );

  // output register: loaded by the walk or by a file end with no result yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (walk_done || emit_one) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (walk_done) begin
      orient_q <= walk_res;
    end else if (emit_one) begin
      orient_q <= ORIENT_DEFAULT;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign orientation_o = orient_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_start |-> !walk_busy)
    else $error("walk started while a walk is running");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_done || emit_one) |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a held result");

  a_single_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walk_done && emit_one) && !(walk_start && emit_one))
    else $error("two result sources in one cycle");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (orient_q >= 4'd1 && orient_q <= 4'd8))
    else $error("orientation out of range");

endmodule
